// File: design/dbk_pkg.sv
// ----------------------------------------------------------------------------
// dbk_pkg
// Shared codes, controller states and the control/status bundles between
// the edge-table controller and its datapath.
// ----------------------------------------------------------------------------
package dbk_pkg;

    // item commands
    localparam logic [2:0] CMD_SEQ  = 3'd0;
    localparam logic [2:0] CMD_NEXT = 3'd1;
    localparam logic [2:0] CMD_PREV = 3'd2;
    localparam logic [2:0] CMD_OUT1 = 3'd3;
    localparam logic [2:0] CMD_IN1  = 3'd4;
    localparam logic [2:0] CMD_NODE = 3'd5;

    // symbol codes
    localparam logic [2:0] SYM_A      = 3'd0;
    localparam logic [2:0] SYM_C      = 3'd1;
    localparam logic [2:0] SYM_G      = 3'd2;
    localparam logic [2:0] SYM_T      = 3'd3;
    localparam logic [2:0] SYM_N      = 3'd4;
    localparam logic [2:0] SYM_DOLLAR = 3'd5;
    localparam logic [2:0] NUM_SYMS   = 3'd6;

    // result status
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_NBR  = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    localparam logic [3:0] ORDER_RESET = 4'd15;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SEQ,
        S_QRD,
        S_QEVAL,
        S_QNEXT,
        S_HASH,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_PAD,
        PH_WIN,
        PH_END,
        PH_FIN,
        PH_QRY
    } t_phase;

    typedef enum logic [1:0] {
        KS_PAD,
        KS_WIN,
        KS_END,
        KS_QRY
    } t_key_sel;

    typedef struct packed {
        logic     accept;
        logic     clr_step;
        logic     pad_init;
        logic     pad_step;
        logic     key_load;
        t_key_sel key_sel;
        logic     hash_load;
        logic     slot_inc;
        logic     do_insert;
        logic     hit_rec;
        logic     cand_clr;
        logic     cand_inc;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_seq;
        logic in_qry;
        logic is_node;
        logic first_only;
        logic do_pad;
        logic pad_more;
        logic do_win;
        logic do_end;
        logic oor;
        logic cand_more;
        logic hit;
        logic slot_valid;
        logic slot_match;
    } t_dp_stat;

endpackage

// File: design/dbk_in_if.sv
// ----------------------------------------------------------------------------
// dbk_in_if
// Input channel: valid/ready with one command item as payload.
// ----------------------------------------------------------------------------
interface dbk_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  seq_byte;
    logic        seq_first;
    logic        seq_last;
    logic        rooted_mode;
    logic [11:0] edge_sel;
    logic [2:0]  step_label;

    modport source (
        output valid, cmd, seq_byte, seq_first, seq_last, rooted_mode, edge_sel,
               step_label,
        input  ready
    );
    modport sink (
        input  valid, cmd, seq_byte, seq_first, seq_last, rooted_mode, edge_sel,
               step_label,
        output ready
    );
endinterface

// File: design/dbk_out_if.sv
// ----------------------------------------------------------------------------
// dbk_out_if
// Result channel: valid/ready with one result item as payload.
// ----------------------------------------------------------------------------
interface dbk_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] found_edge;
    logic        answer_bit;
    logic [44:0] node_symbols;
    logic [4:0]  new_edges;
    logic [12:0] edges_total;
    logic [1:0]  status;

    modport source (
        output valid, found_edge, answer_bit, node_symbols, new_edges, edges_total,
               status,
        input  ready
    );
    modport sink (
        input  valid, found_edge, answer_bit, node_symbols, new_edges, edges_total,
               status,
        output ready
    );
endinterface

// File: design/dbk_ctrl.sv
// ----------------------------------------------------------------------------
// dbk_ctrl
// Sequencer: clearing pass, insert sequence per byte, query candidate walk,
// hash probe loop and result hand-off.
// ----------------------------------------------------------------------------
module dbk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  dbk_pkg::t_dp_stat i_stat,
    output dbk_pkg::t_dp_cmd  o_cmd
);
    import dbk_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_phase  <= PH_FIN;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_ovalid   = r_ovalid & ~i_out_ready;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clr_step = 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_seq) begin
                        n_state = S_INIT;
                    end else if (i_stat.in_qry) begin
                        n_state = S_QRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INIT: begin
                o_cmd.pad_init = 1'b1;
                n_phase        = PH_PAD;
                n_state        = S_SEQ;
            end
            S_SEQ: begin
                case (r_phase)
                    PH_PAD: begin
                        if (i_stat.do_pad && i_stat.pad_more) begin
                            o_cmd.key_load = 1'b1;
                            o_cmd.key_sel  = KS_PAD;
                            n_state        = S_HASH;
                        end else begin
                            n_phase = PH_WIN;
                        end
                    end
                    PH_WIN: begin
                        n_phase = PH_END;
                        if (i_stat.do_win) begin
                            o_cmd.key_load = 1'b1;
                            o_cmd.key_sel  = KS_WIN;
                            n_state        = S_HASH;
                        end
                    end
                    PH_END: begin
                        n_phase = PH_FIN;
                        if (i_stat.do_win && i_stat.do_end) begin
                            o_cmd.key_load = 1'b1;
                            o_cmd.key_sel  = KS_END;
                            n_state        = S_HASH;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_QRD: begin
                n_state = S_QEVAL;
            end
            S_QEVAL: begin
                if (i_stat.oor || i_stat.is_node) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.cand_clr = 1'b1;
                    n_phase        = PH_QRY;
                    n_state        = S_QNEXT;
                end
            end
            S_QNEXT: begin
                if (i_stat.cand_more && !(i_stat.first_only && i_stat.hit)) begin
                    o_cmd.key_load = 1'b1;
                    o_cmd.key_sel  = KS_QRY;
                    n_state        = S_HASH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_HASH: begin
                o_cmd.hash_load = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.slot_valid && !i_stat.slot_match) begin
                    // collision: linear probe to next slot
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_READ;
                end else begin
                    if (r_phase == PH_QRY) begin
                        o_cmd.hit_rec  = i_stat.slot_valid;
                        o_cmd.cand_inc = 1'b1;
                        n_state        = S_QNEXT;
                    end else begin
                        o_cmd.do_insert = ~i_stat.slot_valid;
                        o_cmd.pad_step  = (r_phase == PH_PAD);
                        n_state         = S_SEQ;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

// File: design/dbk_dp.sv
// ----------------------------------------------------------------------------
// dbk_dp
// Datapath: symbol window, key builder, hashed slot memory, edge word
// memory, fill count and result register.
// ----------------------------------------------------------------------------
module dbk_dp #(
    parameter int MAX_EDGE_SYMBOLS = 16,
    parameter int TABLE_CAPACITY   = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic [2:0]        i_cmd,
    input  logic [7:0]        i_seq_byte,
    input  logic              i_seq_first,
    input  logic              i_seq_last,
    input  logic              i_rooted_mode,
    input  logic [11:0]       i_edge_sel,
    input  logic [2:0]        i_step_label,
    input  dbk_pkg::t_dp_cmd  i_ctl,
    output dbk_pkg::t_dp_stat o_stat,
    output logic [11:0]       o_found_edge,
    output logic              o_answer_bit,
    output logic [44:0]       o_node_symbols,
    output logic [4:0]        o_new_edges,
    output logic [12:0]       o_edges_total,
    output logic [1:0]        o_status
);
    import dbk_pkg::*;

    localparam int W     = 3 * MAX_EDGE_SYMBOLS;
    localparam int IW    = $clog2(TABLE_CAPACITY);
    localparam int CW    = $clog2(TABLE_CAPACITY + 1);
    localparam int SW    = IW + 1;
    localparam int EW    = 1 + W + IW;
    localparam int NCH   = (W + SW - 1) / SW;
    localparam int XW    = (CW > 12) ? CW : 12;
    localparam int KMAX  = MAX_EDGE_SYMBOLS - 1;

    function automatic logic [W-1:0] f_mask(input logic [4:0] n);
        logic [W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_EDGE_SYMBOLS; i++) begin
            m[3*i +: 3] = (i < int'(n)) ? 3'b111 : 3'b000;
        end
        return m;
    endfunction

    function automatic logic [W-1:0] f_place(input logic [2:0] sym, input logic [4:0] pos);
        return W'(sym) << (3 * int'(pos));
    endfunction

    function automatic logic [SW-1:0] f_hash(input logic [W-1:0] key);
        logic [SW-1:0] h;
        h = '0;
        for (int i = 0; i < NCH; i++) begin
            h = h ^ SW'(key >> (i * SW));
        end
        return h;
    endfunction

    function automatic logic [2:0] f_encode(input logic [7:0] b);
        logic [2:0] s;
        case (b)
            8'h41:   s = SYM_A;
            8'h43:   s = SYM_C;
            8'h47:   s = SYM_G;
            8'h54:   s = SYM_T;
            8'h4E:   s = SYM_N;
            8'h24:   s = SYM_DOLLAR;
            default: s = SYM_N;
        endcase
        return s;
    endfunction

    // control state
    logic [3:0]     r_order;
    logic [W-1:0]   r_window;
    logic [4:0]     r_seen;
    logic           r_rooted;
    logic [CW-1:0]  r_fill;
    logic [SW:0]    r_clr;

    // per-item working registers
    logic [2:0]     r_cmd;
    logic           r_last;
    logic [11:0]    r_sel;
    logic [2:0]     r_step;
    logic [W-1:0]   r_pad;
    logic [W-1:0]   r_wcopy;
    logic [4:0]     r_pcnt;
    logic [W-1:0]   r_key;
    logic [SW-1:0]  r_slot;
    logic [2:0]     r_cand;
    logic           r_hit;
    logic [IW-1:0]  r_hidx;
    logic [2:0]     r_count;
    logic [4:0]     r_added;
    logic           r_drop;

    // memories
    logic [EW-1:0]  hmem [0:(1<<SW)-1];
    logic [W-1:0]   emem [0:TABLE_CAPACITY-1];
    logic [EW-1:0]  r_hrd;
    logic [W-1:0]   r_erd;

    logic [3:0]     w_k;
    logic [4:0]     w_k5;
    logic [4:0]     w_k1;
    logic [4:0]     w_km1;
    logic [W-1:0]   w_head;
    logic [2:0]     w_lab;
    logic [W-1:0]   w_qkey;
    logic [W-1:0]   w_nkey;
    logic           w_full;
    logic           w_oor;
    logic           w_ins_ok;
    logic [IW-1:0]  w_eaddr;
    logic [4:0]     w_seen_nx;

    always_comb begin
        if (r_order == 4'd0) begin
            w_k = 4'd1;
        end else if (int'(r_order) > KMAX) begin
            w_k = 4'(KMAX);
        end else begin
            w_k = r_order;
        end
    end

    assign w_k5    = {1'b0, w_k};
    assign w_k1    = w_k5 + 5'd1;
    assign w_km1   = w_k5 - 5'd1;
    assign w_head  = r_erd & f_mask(w_k5);
    assign w_lab   = (r_step >= NUM_SYMS) ? SYM_N : r_step;
    assign w_full  = (r_fill == CW'(TABLE_CAPACITY));
    assign w_oor   = (XW'(r_sel) >= XW'(r_fill));
    assign w_ins_ok = i_ctl.do_insert && !w_full;
    assign w_eaddr = IW'(r_sel);
    assign w_seen_nx = i_seq_first ? 5'd1 :
                       ((r_seen == 5'd31) ? r_seen : r_seen + 5'd1);

    // neighbor candidate key for the query walk
    always_comb begin
        case (r_cmd)
            CMD_NEXT: w_qkey = ((r_erd >> 3) & f_mask(w_km1)) | f_place(w_lab, w_km1)
                               | f_place(r_cand, w_k5);
            CMD_OUT1: w_qkey = w_head | f_place(r_cand, w_k5);
            default:  w_qkey = W'(r_cand) | (w_head << 3);
        endcase
    end

    always_comb begin
        case (i_ctl.key_sel)
            KS_PAD:  w_nkey = r_pad;
            KS_WIN:  w_nkey = r_window;
            KS_END:  w_nkey = (r_window >> 3) | f_place(SYM_DOLLAR, w_k5);
            default: w_nkey = w_qkey;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= ORDER_RESET;
            r_window <= '0;
            r_seen   <= '0;
            r_rooted <= 1'b0;
            r_fill   <= '0;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
            end
            if (i_ctl.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_ctl.accept && i_cmd == CMD_SEQ) begin
                r_seen   <= w_seen_nx;
                r_window <= ((r_window >> 3) | f_place(f_encode(i_seq_byte), w_k5))
                            & f_mask(w_k1);
                if (i_seq_first) begin
                    r_rooted <= i_rooted_mode;
                end
            end
            if (w_ins_ok) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd   <= i_cmd;
            r_last  <= i_seq_last;
            r_sel   <= i_edge_sel;
            r_step  <= i_step_label;
            r_hit   <= 1'b0;
            r_count <= '0;
            r_added <= '0;
            r_drop  <= 1'b0;
        end
        if (i_ctl.pad_init) begin
            r_pad   <= ~'0 & f_mask(w_k1) & {MAX_EDGE_SYMBOLS{SYM_DOLLAR}};
            r_wcopy <= r_window;
            r_pcnt  <= '0;
        end
        if (i_ctl.pad_step) begin
            r_pad   <= (r_pad >> 3) | f_place(r_wcopy[2:0], w_k5);
            r_wcopy <= r_wcopy >> 3;
            r_pcnt  <= r_pcnt + 5'd1;
        end
        if (i_ctl.key_load) begin
            r_key <= w_nkey;
        end
        if (i_ctl.hash_load) begin
            r_slot <= f_hash(r_key);
        end else if (i_ctl.slot_inc) begin
            r_slot <= r_slot + 1'b1;
        end
        if (i_ctl.cand_clr) begin
            r_cand <= '0;
        end else if (i_ctl.cand_inc) begin
            r_cand <= r_cand + 3'd1;
        end
        if (i_ctl.hit_rec) begin
            r_count <= r_count + 3'd1;
            if (!r_hit) begin
                r_hit  <= 1'b1;
                r_hidx <= r_hrd[IW-1:0];
            end
        end
        if (i_ctl.do_insert) begin
            if (w_full) begin
                r_drop <= 1'b1;
            end else begin
                r_added <= r_added + 5'd1;
            end
        end
    end

    // slot memory: {valid, word, edge index}
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) begin
            hmem[r_clr[SW-1:0]] <= '0;
        end else if (w_ins_ok) begin
            hmem[r_slot] <= {1'b1, r_key, IW'(r_fill)};
        end
        r_hrd <= hmem[r_slot];
    end

    // edge word memory, dense by index
    always_ff @(posedge i_clk) begin
        if (w_ins_ok) begin
            emem[IW'(r_fill)] <= r_key;
        end
        r_erd <= emem[w_eaddr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            o_found_edge   <= '0;
            o_answer_bit   <= 1'b0;
            o_node_symbols <= '0;
            o_new_edges    <= r_added;
            o_edges_total  <= 13'(r_fill);
            o_status       <= STAT_OK;
            case (r_cmd)
                CMD_SEQ: begin
                    o_status <= r_drop ? STAT_FULL : STAT_OK;
                end
                CMD_NEXT, CMD_PREV: begin
                    if (w_oor) begin
                        o_status <= STAT_RANGE;
                    end else if (r_hit) begin
                        o_found_edge <= 12'(r_hidx);
                    end else begin
                        o_status <= STAT_NO_NBR;
                    end
                end
                CMD_OUT1, CMD_IN1: begin
                    if (w_oor) begin
                        o_status <= STAT_RANGE;
                    end else begin
                        o_answer_bit <= (r_count == 3'd1);
                    end
                end
                CMD_NODE: begin
                    if (w_oor) begin
                        o_status <= STAT_RANGE;
                    end else begin
                        o_node_symbols <= 45'(w_head);
                    end
                end
                default: begin
                    o_status <= STAT_OK;
                end
            endcase
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.clr_done   = r_clr[SW];
        o_stat.in_seq     = (i_cmd == CMD_SEQ);
        o_stat.in_qry     = i_cmd inside {[CMD_NEXT:CMD_NODE]};
        o_stat.is_node    = (r_cmd == CMD_NODE);
        o_stat.first_only = (r_cmd == CMD_NEXT) || (r_cmd == CMD_PREV);
        o_stat.do_pad     = (r_seen == w_k1) && !r_rooted;
        o_stat.pad_more   = (r_pcnt <= w_k5);
        o_stat.do_win     = (r_seen >= w_k1);
        o_stat.do_end     = r_last && !r_rooted;
        o_stat.oor        = w_oor;
        o_stat.cand_more  = (r_cand < NUM_SYMS);
        o_stat.hit        = r_hit;
        o_stat.slot_valid = r_hrd[EW-1];
        o_stat.slot_match = (r_hrd[IW +: W] == r_key);
    end

endmodule

// File: design/de_bruijn_kmer_edge_table.sv
// ----------------------------------------------------------------------------
// de_bruijn_kmer_edge_table
// Distinct edge k-mer table of a de Bruijn graph with dense indexes and
// exact-match lookup through a linear-probed hash slot memory.
// ----------------------------------------------------------------------------
// Probes: a sequence byte runs one hash probe per padded k-mer, window or
//   closing k-mer, and each slot collision adds a read; the first full
//   window of an unrooted sequence takes up to k+3 probes. Queries out of
//   range or for a node k-mer skip the probe loop, else probe each candidate
//   (up to six); unknown commands go straight to the result. The result is
//   registered before the next transfer can be taken; one item at a time,
//   the slot memory's single read port sets the rate.
// Reset: synchronous; afterwards a clearing pass walks the slot memory's
//   2^(clog2(TABLE_CAPACITY)+1) slots (8192 at default); no item is taken
//   meanwhile.
// ----------------------------------------------------------------------------
module de_bruijn_kmer_edge_table #(
    parameter int MAX_EDGE_SYMBOLS = 16,
    parameter int TABLE_CAPACITY   = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    dbk_in_if.sink     i_in,
    dbk_out_if.source  o_out
);
    import dbk_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller: one item in flight; result register lets the next item
    // transfer in while the previous result waits
    dbk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: window, key build, slot/edge memories, result fields
    dbk_dp #(
        .MAX_EDGE_SYMBOLS (MAX_EDGE_SYMBOLS),
        .TABLE_CAPACITY   (TABLE_CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_in.cmd),
        .i_seq_byte     (i_in.seq_byte),
        .i_seq_first    (i_in.seq_first),
        .i_seq_last     (i_in.seq_last),
        .i_rooted_mode  (i_in.rooted_mode),
        .i_edge_sel     (i_in.edge_sel),
        .i_step_label   (i_in.step_label),
        .i_ctl          (w_cmd),
        .o_stat         (w_stat),
        .o_found_edge   (o_out.found_edge),
        .o_answer_bit   (o_out.answer_bit),
        .o_node_symbols (o_out.node_symbols),
        .o_new_edges    (o_out.new_edges),
        .o_edges_total  (o_out.edges_total),
        .o_status       (o_out.status)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks de_bruijn_kmer_edge_table against a behavioral model of the k-mer
// edge table kept in a scoreboard class. Directed items first, then random
// sequences, graph queries and stray items at several k-mer orders, ending
// with a run that fills the table and drives inserts past capacity.
// ----------------------------------------------------------------------------
module testbench;
    import dbk_pkg::*;

    localparam int          EDGE_CAPACITY = 4096;
    localparam int          CYCLE_LIMIT   = 3000000;
    localparam int          HOLD_CYCLES   = 400;
    localparam logic [2:0]  CMD_SPARE_LO  = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  seq_byte;
        logic        seq_first;
        logic        seq_last;
        logic        rooted_mode;
        logic [11:0] edge_sel;
        logic [2:0]  step_label;
    } t_item;

    typedef struct packed {
        logic [11:0] found_edge;
        logic        answer_bit;
        logic [44:0] node_symbols;
        logic [4:0]  new_edges;
        logic [12:0] edges_total;
        logic [1:0]  status;
    } t_answer;

    // ------------------------------------------------------------------------
    // Scoreboard: edge table model plus the queue of expected answers
    // ------------------------------------------------------------------------
    class edge_table_scoreboard;
        logic [63:0] edge_words [EDGE_CAPACITY];
        int unsigned word_slot [logic [63:0]];
        int unsigned fill;
        logic [63:0] window;
        int unsigned seen;
        bit          rooted;
        logic [3:0]  order;
        t_answer     expected_answers [$];
        int          errors;

        function new();
            fill   = 0;
            window = '0;
            seen   = 0;
            rooted = 0;
            order  = ORDER_RESET;
            errors = 0;
        endfunction

        function void set_order(logic [3:0] v);
            order = v;
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        function logic [63:0] sym_mask(int unsigned n);
            if (n == 0) return '0;
            return (64'd1 << (3 * n)) - 64'd1;
        endfunction

        function logic [2:0] encode(logic [7:0] b);
            case (b)
                "A": return SYM_A;
                "C": return SYM_C;
                "G": return SYM_G;
                "T": return SYM_T;
                "$": return SYM_DOLLAR;
                default: return SYM_N;
            endcase
        endfunction

        // 0 present, 1 added, 2 dropped (table full)
        function int add_word(logic [63:0] w);
            if (word_slot.exists(w)) return 0;
            if (fill >= EDGE_CAPACITY) return 2;
            edge_words[fill] = w;
            word_slot[w]     = fill;
            fill++;
            return 1;
        endfunction

        function void tally(int r, ref int unsigned added, ref bit dropped);
            if (r == 1) added++;
            else if (r == 2) dropped = 1;
        endfunction

        function void note_input(t_item it);
            int unsigned k, p, j, c, cnt, added, hit_slot;
            logic [63:0] pad, e, head, base, w;
            logic [2:0]  lab;
            bit          dropped, hit;
            t_answer     a;
            a       = '0;
            added   = 0;
            dropped = 0;
            k = (order == 0) ? 1 : order;
            if (it.cmd == CMD_SEQ) begin
                if (it.seq_first) begin
                    seen   = 0;
                    rooted = it.rooted_mode;
                end
                window = ((window >> 3) | (64'(encode(it.seq_byte)) << (3 * k)))
                         & sym_mask(k + 1);
                if (seen < 31) seen++;
                // padded k-mers all land when the window first fills
                if (seen == k + 1 && !rooted) begin
                    for (p = 0; p <= k; p++) begin
                        pad = '0;
                        for (j = 0; j < k + 1 - p; j++) pad |= 64'(SYM_DOLLAR) << (3 * j);
                        tally(add_word(pad | ((window & sym_mask(p)) << (3 * (k + 1 - p)))),
                              added, dropped);
                    end
                end
                if (seen >= k + 1) begin
                    tally(add_word(window), added, dropped);
                    if (it.seq_last && !rooted)
                        tally(add_word((window >> 3) | (64'(SYM_DOLLAR) << (3 * k))),
                              added, dropped);
                end
                a.new_edges = 5'(added);
                a.status    = dropped ? STAT_FULL : STAT_OK;
            end else if (it.cmd <= CMD_NODE) begin
                if (it.edge_sel >= fill) begin
                    a.status = STAT_RANGE;
                end else begin
                    e    = edge_words[it.edge_sel];
                    head = e & sym_mask(k);
                    hit  = 0;
                    cnt  = 0;
                    case (it.cmd)
                        CMD_NEXT: begin
                            lab  = (it.step_label >= NUM_SYMS) ? SYM_N : it.step_label;
                            base = ((e >> 3) & sym_mask(k - 1)) | (64'(lab) << (3 * (k - 1)));
                            for (c = 0; c < NUM_SYMS && !hit; c++) begin
                                w = base | (64'(c) << (3 * k));
                                if (word_slot.exists(w)) begin
                                    hit      = 1;
                                    hit_slot = word_slot[w];
                                end
                            end
                        end
                        CMD_PREV: begin
                            for (c = 0; c < NUM_SYMS && !hit; c++) begin
                                w = 64'(c) | (head << 3);
                                if (word_slot.exists(w)) begin
                                    hit      = 1;
                                    hit_slot = word_slot[w];
                                end
                            end
                        end
                        CMD_OUT1: begin
                            for (c = 0; c < NUM_SYMS; c++)
                                if (word_slot.exists(head | (64'(c) << (3 * k)))) cnt++;
                            a.answer_bit = (cnt == 1);
                        end
                        CMD_IN1: begin
                            for (c = 0; c < NUM_SYMS; c++)
                                if (word_slot.exists(64'(c) | (head << 3))) cnt++;
                            a.answer_bit = (cnt == 1);
                        end
                        default: a.node_symbols = head[44:0];
                    endcase
                    if (it.cmd == CMD_NEXT || it.cmd == CMD_PREV) begin
                        if (hit) a.found_edge = 12'(hit_slot);
                        else a.status = STAT_NO_NBR;
                    end
                end
            end
            a.edges_total = 13'(fill);
            expected_answers.insert(expected_answers.size(), a);
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_result(t_answer got);
            t_answer want;
            if (expected_answers.size() == 0) begin
                complain($sformatf("unexpected result: %p", got));
                return;
            end
            want = expected_answers.pop_front();
            if (got.found_edge !== want.found_edge || got.answer_bit !== want.answer_bit ||
                got.node_symbols !== want.node_symbols || got.new_edges !== want.new_edges ||
                got.edges_total !== want.edges_total || got.status !== want.status)
                complain($sformatf("mismatch: expected %p actual %p", want, got));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [3:0] i_cfg_data;

    dbk_in_if  in_ch ();
    dbk_out_if out_ch ();

    edge_table_scoreboard sb = new();

    int cycle_count;
    int burst_left;
    int hold_requests;  // raised by stimulus, served by the receiver
    int hold_served;

    de_bruijn_kmer_edge_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: checks every result transfer; ready follows a stall pattern
    // of redrawn density (0, 25 or 70 percent), plus long hold-offs on request.
    // ------------------------------------------------------------------------
    int stall_pct;
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_pct    = 0;
            hold_left    = 0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result({out_ch.found_edge, out_ch.answer_bit, out_ch.node_symbols,
                                 out_ch.new_edges, out_ch.edges_total, out_ch.status});
            if (cycle_count % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 70;
                endcase
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    // One input transfer; valid stays high across a burst, drops for a gap.
    task automatic send(t_item it);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= it.cmd;
        in_ch.seq_byte    <= it.seq_byte;
        in_ch.seq_first   <= it.seq_first;
        in_ch.seq_last    <= it.seq_last;
        in_ch.rooted_mode <= it.rooted_mode;
        in_ch.edge_sel    <= it.edge_sel;
        in_ch.step_label  <= it.step_label;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_byte(logic [7:0] b, bit first, bit last, bit root);
        send({CMD_SEQ, b, first, last, root, 12'($urandom_range(0, 4095)),
              3'($urandom_range(0, 7))});
    endtask

    task automatic send_query(logic [2:0] cmd, logic [11:0] sel, logic [2:0] lab);
        send({cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sel, lab});
    endtask

    // Wait out all results, then let the block settle before a register write.
    task automatic write_order(logic [3:0] v);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_order(v);
    endtask

    function automatic logic [7:0] dna_char();
        case ($urandom_range(0, 5))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            4: return "N";
            default: return "$";
        endcase
    endfunction

    function automatic logic [11:0] pick_edge();
        if (sb.fill > 0 && $urandom_range(0, 99) < 85)
            return 12'($urandom_range(0, sb.fill - 1));
        return 12'($urandom_range(0, 4095));
    endfunction

    // Mostly well-formed sequences with queries between them; some noise.
    task automatic random_phase(int n_items);
        int done, len, i, k, roll;
        bit root, closes;
        done = 0;
        while (done < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                k      = (sb.order == 0) ? 1 : sb.order;
                len    = $urandom_range(1, k + 6);
                root   = ($urandom_range(0, 3) == 0);
                closes = ($urandom_range(0, 9) != 0);
                for (i = 0; i < len; i++)
                    send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                          : dna_char(),
                              i == 0, closes && i == len - 1, root);
                done += len;
            end else if (roll < 92) begin
                send_query(3'($urandom_range(CMD_NEXT, CMD_NODE)), pick_edge(),
                           3'($urandom_range(0, 7)));
                done++;
            end else if (roll < 97) begin
                // stray byte continuing whatever sequence is open
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                done++;
            end else begin
                send_query(($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO,
                           12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)));
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        cycle_count   = 0;
        burst_left    = 0;
        hold_requests = 0;
        hold_served   = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= ORDER_RESET;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_SEQ;
        in_ch.seq_byte    <= '0;
        in_ch.seq_first   <= 1'b0;
        in_ch.seq_last    <= 1'b0;
        in_ch.rooted_mode <= 1'b0;
        in_ch.edge_sel    <= '0;
        in_ch.step_label  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at k = 3
        write_order(4'd3);
        send_byte("A", 1, 0, 0);
        send_byte("C", 0, 0, 0);
        send_byte("G", 0, 0, 0);
        send_byte("T", 0, 0, 0);          // window full: padded k-mers land
        send_byte(8'hFF, 0, 0, 0);        // outside the alphabet, becomes N
        send_byte("$", 0, 0, 0);
        send_byte("N", 0, 1, 0);          // closing '$' k-mer
        send_byte("G", 0, 0, 0);          // continues past the last mark
        send_byte("A", 1, 1, 0);          // too short to insert anything
        send_byte(8'h00, 1, 0, 1);        // rooted, no padding
        send_byte("a", 0, 0, 1);
        send_byte("C", 0, 0, 1);
        send_byte("T", 0, 1, 1);
        send_query(CMD_NEXT, 12'd0, SYM_A);
        send_query(CMD_NEXT, 12'd3, SYM_DOLLAR);
        send_query(CMD_NEXT, 12'd5, 3'd7); // label above five acts as N
        send_query(CMD_PREV, 12'd4, SYM_A);
        send_query(CMD_PREV, 12'd0, SYM_A);
        send_query(CMD_OUT1, 12'd1, SYM_A);
        send_query(CMD_IN1, 12'd6, SYM_A);
        send_query(CMD_NODE, 12'd2, SYM_A);
        send_query(CMD_NODE, 12'd4095, SYM_A); // out of range
        send_query(CMD_PREV, 12'(sb.fill), SYM_A);
        send_query(CMD_SPARE_LO, 12'd0, SYM_A);
        send_query(CMD_SPARE_HI, 12'd1, SYM_A);

        // random phases over several orders; earlier words stay in the table
        write_order(4'd1);
        random_phase(120);
        write_order(4'd0);                // acts as 1
        random_phase(110);
        write_order(4'd2);
        hold_requests++;                  // receiver backs off, so the input stalls
        random_phase(120);
        write_order(4'd15);
        random_phase(120);
        write_order(4'd7);
        random_phase(110);
        write_order(4'($urandom_range(4, 12)));
        random_phase(110);

        // fill the table: k is the byte count less one, so each byte but the
        // first is a first full window: padded k-mers, window and closing word
        while (sb.fill < EDGE_CAPACITY) begin
            for (int s = 1; s <= 16; s++) begin
                write_order(4'((s == 1) ? 1 : s - 1));
                send_byte(dna_char(), s == 1, 1'b1, 1'b0);
            end
        end
        // keep inserting once it is full
        write_order(4'd15);
        for (int i = 0; i < 40; i++) send_byte(dna_char(), i == 0, i == 39, 0);
        for (int i = 0; i < 20; i++)
            send_query(3'($urandom_range(CMD_NEXT, CMD_NODE)), pick_edge(),
                       3'($urandom_range(0, 7)));

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
